@@ rtl/pmul_pkg.sv @@
// Package with the shared sizes, types and command format of the polynomial multiply core.
package pmul_pkg;

  // Capacity of each operand store and the coefficient width that is kept.
  localparam int MAX_TERMS = 16;
  localparam int COEF_BITS = 16;

  // Fixed widths of the stream fields.
  localparam int IN_COEF_W   = 16;
  localparam int ACC_W       = 36;
  localparam int DEG_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = ACC_W + DEG_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Derived sizes.
  localparam int EFF_BITS = (COEF_BITS < IN_COEF_W) ? COEF_BITS : IN_COEF_W;
  localparam int IDX_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W    = $clog2(MAX_TERMS + 1);
  localparam int KW       = $clog2(2 * MAX_TERMS);
  localparam int PROD_W   = 2 * EFF_BITS;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // Operand selector codes.
  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

  // One command: an optional store write and an optional product run.
  typedef struct packed {
    logic                wr;
    logic                sel;
    logic [IDX_W-1:0]    addr;
    logic [EFF_BITS-1:0] value;
    logic                run;
    logic [CNT_W-1:0]    n_first;
    logic [CNT_W-1:0]    n_second;
  } cmd_t;

endpackage

@@ rtl/polynomial_multiply_core.sv @@
// Top level of the polynomial multiply core: front end, command queue and back end.
//
// The core loads two integer polynomials one signed coefficient per beat, lowest degree
// first; tuser picks the operand (0 first, 1 second) and tlast closes it. Coefficients past
// the store capacity are dropped, though their tlast still closes the operand, and beats for
// an operand that is already closed are ignored. Once both operands are closed the core
// emits the n1+n2-1 coefficients of the product, degree 0 first, with tlast on the highest
// degree, and both operands start over. Every input beat is taken by the front end and
// passed through a four-entry command queue, so loading the next pair goes on while a
// product is being computed, until the queue fills. While idle, the back end retires one
// queued command per cycle. The product itself runs on a single multiplier that does one
// coefficient pair per cycle while the output is not held off. The last product coefficient
// passes the operand, product and output registers in order, and once the operand and
// product stages are empty the back end takes commands again. Results leave through a
// single register; while a result beat waits for m_tready the whole multiply pipeline
// stalls, so holding off the output delays the product.
module polynomial_multiply_core (
  input  logic                             clk,
  input  logic                             rst,
  // Input beats.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pmul_pkg::IN_TDATA_W-1:0]  s_tdata,  // [15:0] coef
  input  logic                             s_tuser,  // [0] req_type
  input  logic                             s_tlast,  // coef_last
  // Result beats.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pmul_pkg::OUT_TDATA_W-1:0] m_tdata,  // [35:0] prod_coef, [40:36] prod_degree
  output logic                             m_tlast   // prod_last
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  pmul_pkg::cmd_t push_cmd;
  pmul_pkg::cmd_t pop_cmd;

  pmul_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  pmul_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  pmul_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/pmul_front.sv @@
// Front end: accepts coefficient beats, tracks operand fill state and issues commands.
module pmul_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pmul_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  input  logic                             q_full,
  output logic                             q_push,
  output pmul_pkg::cmd_t                   q_cmd
);

  logic [pmul_pkg::CNT_W-1:0] cnt_a;
  logic [pmul_pkg::CNT_W-1:0] cnt_b;
  logic                       done_a;
  logic                       done_b;

  logic [pmul_pkg::CNT_W-1:0] cur_cnt;
  logic [pmul_pkg::CNT_W-1:0] oth_cnt;
  logic [pmul_pkg::CNT_W-1:0] new_cnt;
  logic                       cur_done;
  logic                       oth_done;
  logic                       has_room;
  logic                       take;
  logic                       live;
  logic                       run;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    cur_cnt  = (s_tuser == pmul_pkg::SEL_SECOND) ? cnt_b : cnt_a;
    oth_cnt  = (s_tuser == pmul_pkg::SEL_SECOND) ? cnt_a : cnt_b;
    cur_done = (s_tuser == pmul_pkg::SEL_SECOND) ? done_b : done_a;
    oth_done = (s_tuser == pmul_pkg::SEL_SECOND) ? done_a : done_b;
    has_room = cur_cnt < pmul_pkg::CNT_W'(pmul_pkg::MAX_TERMS);
    new_cnt  = has_room ? cur_cnt + pmul_pkg::CNT_W'(1) : cur_cnt;
    live     = take && !cur_done;
    run      = live && s_tlast && oth_done;

    q_cmd.wr       = live && has_room;
    q_cmd.sel      = s_tuser;
    q_cmd.addr     = cur_cnt[pmul_pkg::IDX_W-1:0];
    q_cmd.value    = s_tdata[pmul_pkg::EFF_BITS-1:0];
    q_cmd.run      = run;
    q_cmd.n_first  = (s_tuser == pmul_pkg::SEL_SECOND) ? oth_cnt : new_cnt;
    q_cmd.n_second = (s_tuser == pmul_pkg::SEL_SECOND) ? new_cnt : oth_cnt;
    q_push         = q_cmd.wr || run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a  <= '0;
      cnt_b  <= '0;
      done_a <= 1'b0;
      done_b <= 1'b0;
    end else if (live) begin
      if (run) begin
        // The pair is complete, so both operands start over.
        cnt_a  <= '0;
        cnt_b  <= '0;
        done_a <= 1'b0;
        done_b <= 1'b0;
      end else if (s_tuser == pmul_pkg::SEL_SECOND) begin
        cnt_b  <= new_cnt;
        done_b <= s_tlast;
      end else begin
        cnt_a  <= new_cnt;
        done_a <= s_tlast;
      end
    end
  end

endmodule

@@ rtl/pmul_queue.sv @@
// Short first-in first-out queue of commands between the front and the back.
module pmul_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pmul_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output pmul_pkg::cmd_t pop_cmd,
  output logic           empty
);

  pmul_pkg::cmd_t              slots [pmul_pkg::QUEUE_DEPTH];
  logic [pmul_pkg::QP_W-1:0]   wr_ptr;
  logic [pmul_pkg::QP_W-1:0]   rd_ptr;
  logic [pmul_pkg::QP_W:0]     fill;
  logic                        do_push;
  logic                        do_pop;

  assign full    = fill == (pmul_pkg::QP_W + 1)'(pmul_pkg::QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + pmul_pkg::QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + pmul_pkg::QP_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + (pmul_pkg::QP_W + 1)'(1);
        2'b01:   fill <= fill - (pmul_pkg::QP_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/pmul_back.sv @@
// Back end: operand stores, the shared multiply-accumulate pipeline and the result register.
module pmul_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  pmul_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pmul_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t state;

  logic [pmul_pkg::EFF_BITS-1:0] mem_a [pmul_pkg::MAX_TERMS];
  logic [pmul_pkg::EFF_BITS-1:0] mem_b [pmul_pkg::MAX_TERMS];

  logic [pmul_pkg::CNT_W-1:0] n1;
  logic [pmul_pkg::CNT_W-1:0] n2;
  logic [pmul_pkg::KW-1:0]    last_k;
  logic [pmul_pkg::KW-1:0]    k;
  logic [pmul_pkg::IDX_W-1:0] i;
  logic                       first_pend;

  // Issue-side arithmetic, one spare bit for the sums.
  logic [pmul_pkg::KW:0]      kx;
  logic [pmul_pkg::KW:0]      k1;
  logic [pmul_pkg::KW:0]      ix;
  logic [pmul_pkg::KW:0]      n1x;
  logic [pmul_pkg::KW:0]      n2x;
  logic [pmul_pkg::KW:0]      hi;
  logic [pmul_pkg::KW:0]      lo_next;
  logic [pmul_pkg::KW:0]      jx;
  logic                       i_last;
  logic                       issue;
  logic                       en;
  logic                       start;

  // Pipeline stage registers.
  logic                                s1_v;
  logic                                s1_first;
  logic                                s1_last;
  logic [pmul_pkg::KW-1:0]             s1_k;
  logic signed [pmul_pkg::EFF_BITS-1:0] a_q;
  logic signed [pmul_pkg::EFF_BITS-1:0] b_q;
  logic                                s2_v;
  logic                                s2_first;
  logic                                s2_last;
  logic [pmul_pkg::KW-1:0]             s2_k;
  logic signed [pmul_pkg::PROD_W-1:0]  prod;
  logic signed [pmul_pkg::ACC_W-1:0]   acc;
  logic signed [pmul_pkg::ACC_W-1:0]   acc_sum;
  logic [pmul_pkg::ACC_W-1:0]          out_coef;
  logic [pmul_pkg::DEG_W-1:0]          out_deg;

  // The whole pipeline moves only when the result register can take a beat.
  assign en    = !m_tvalid || m_tready;
  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign start = q_pop && q_cmd.run && (q_cmd.n_first != '0) && (q_cmd.n_second != '0);
  assign issue = (state == ST_RUN) && en;

  always_comb begin
    kx      = {1'b0, k};
    k1      = kx + (pmul_pkg::KW + 1)'(1);
    ix      = (pmul_pkg::KW + 1)'(i);
    n1x     = (pmul_pkg::KW + 1)'(n1);
    n2x     = (pmul_pkg::KW + 1)'(n2);
    hi      = (kx < n1x) ? kx : n1x - (pmul_pkg::KW + 1)'(1);
    lo_next = (k1 >= n2x) ? k1 - n2x + (pmul_pkg::KW + 1)'(1) : '0;
    jx      = kx - ix;
    i_last  = ix == hi;
    acc_sum = s2_first ? pmul_pkg::ACC_W'(prod) : acc + pmul_pkg::ACC_W'(prod);
  end

  // Operand stores: written from the queue while idle, read by the pipeline.
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr) begin
      if (q_cmd.sel == pmul_pkg::SEL_SECOND) begin
        mem_b[q_cmd.addr] <= q_cmd.value;
      end else begin
        mem_a[q_cmd.addr] <= q_cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q      <= mem_a[i];
      b_q      <= mem_b[jx[pmul_pkg::IDX_W-1:0]];
      s1_first <= first_pend;
      s1_last  <= i_last;
      s1_k     <= k;
      prod     <= a_q * b_q;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_k     <= s1_k;
      if (s2_v) begin
        acc <= acc_sum;
      end
      if (s2_v && s2_last) begin
        out_coef <= acc_sum;
        out_deg  <= pmul_pkg::DEG_W'(s2_k);
        m_tlast  <= s2_k == last_k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      n1         <= '0;
      n2         <= '0;
      last_k     <= '0;
      k          <= '0;
      i          <= '0;
      first_pend <= 1'b0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (en) begin
        s1_v     <= issue;
        s2_v     <= s1_v;
        m_tvalid <= s2_v && s2_last;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            n1         <= q_cmd.n_first;
            n2         <= q_cmd.n_second;
            last_k     <= pmul_pkg::KW'((pmul_pkg::KW + 1)'(q_cmd.n_first)
                          + (pmul_pkg::KW + 1)'(q_cmd.n_second) - (pmul_pkg::KW + 1)'(2));
            k          <= '0;
            i          <= '0;
            first_pend <= 1'b1;
            state      <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (i_last) begin
              first_pend <= 1'b1;
              i          <= lo_next[pmul_pkg::IDX_W-1:0];
              k          <= k1[pmul_pkg::KW-1:0];
              if (k == last_k) begin
                state <= ST_DRAIN;
              end
            end else begin
              first_pend <= 1'b0;
              i          <= i + pmul_pkg::IDX_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (!s1_v && !s2_v) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {{(pmul_pkg::OUT_TDATA_W - pmul_pkg::OUT_FIELD_W){1'b0}}, out_deg, out_coef};

endmodule

@@ rtl/pmul_checker.sv @@
// Port-level checker for the polynomial multiply core and its bind statement.
module pmul_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [pmul_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tlast
);

  logic [pmul_pkg::DEG_W-1:0] exp_deg;
  logic                       out_beat;

  assign out_beat = m_tvalid && m_tready;

  // Degree that the next result beat must carry.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_deg <= '0;
    end else if (out_beat) begin
      exp_deg <= m_tlast ? '0 : exp_deg + pmul_pkg::DEG_W'(1);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat offered right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  a_degree_order: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> m_tdata[pmul_pkg::ACC_W +: pmul_pkg::DEG_W] == exp_deg)
    else $error("product degree out of sequence");

endmodule

bind polynomial_multiply_core pmul_checker u_checker (.*);

@@ dv/tb_polynomial_multiply_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the polynomial multiply core, with a built-in product predictor.
module tb_polynomial_multiply_core;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RESULT = 40;
  localparam int RANDOM_BEATS   = 420;
  localparam int DRAIN_AT_BEAT  = 250;
  localparam int MAX_SHOWN      = 10;

  // Idle pattern of the two stream sides, stepped forward by the count of loaded beats.
  typedef enum logic [1:0] {
    IDLE_SLOW_RX,
    IDLE_SLOW_TX,
    IDLE_NONE
  } idle_phase_t;

  typedef struct {
    logic                           sel;
    logic [pmul_pkg::IN_COEF_W-1:0] coef;
    logic                           last;
    bit                             drain;  // Hold this beat back until every product term has arrived.
  } coef_beat_t;

  typedef struct {
    logic [pmul_pkg::ACC_W-1:0] coef;
    logic [pmul_pkg::DEG_W-1:0] degree;
    logic                       last;
  } prod_term_t;

  logic                             clk      = 1'b0;
  logic                             rst      = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [pmul_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                             s_tuser  = 1'b0;
  logic                             s_tlast  = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [pmul_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tlast;

  // Result fields as seen on the output bus.
  logic [pmul_pkg::ACC_W-1:0]       got_coef;
  logic [pmul_pkg::DEG_W-1:0]       got_deg;

  coef_beat_t  coef_beats_to_send[$];
  prod_term_t  product_terms_due[$];
  idle_phase_t idle_phase = IDLE_SLOW_RX;
  int          results_got = 0;
  int          results_due = 0;
  int          beats_taken = 0;
  int          hold_left   = 0;
  int          mismatch_cnt = 0;
  int          cycle_cnt   = 0;

  // Operand stores of the predictor.
  logic signed [pmul_pkg::EFF_BITS-1:0] first_coefs [pmul_pkg::MAX_TERMS];
  logic signed [pmul_pkg::EFF_BITS-1:0] second_coefs[pmul_pkg::MAX_TERMS];
  int first_len     = 0;
  int second_len    = 0;
  bit first_closed  = 1'b0;
  bit second_closed = 1'b0;

  assign got_coef = m_tdata[pmul_pkg::ACC_W-1:0];
  assign got_deg  = m_tdata[pmul_pkg::ACC_W +: pmul_pkg::DEG_W];

  polynomial_multiply_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic void note_error(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN) $display("ERROR at %0t: %s", $time, what);
  endfunction

  function automatic int idle_pct(input idle_phase_t phase, input bit receiver);
    case (phase)
      IDLE_SLOW_RX: return receiver ? 45 : 25;
      IDLE_SLOW_TX: return receiver ? 25 : 45;
      default:      return 0;
    endcase
  endfunction

  // Loads one accepted beat into the predictor. When both operands are closed, the
  // convolution is formed modulo 2^36 and queued term by term, degree 0 first.
  function automatic void load_and_convolve(input coef_beat_t b);
    logic [pmul_pkg::ACC_W-1:0]        sum;
    logic signed [pmul_pkg::ACC_W-1:0] term;
    prod_term_t                        t;
    int                                n_terms;
    if (b.sel == pmul_pkg::SEL_FIRST) begin
      if (!first_closed) begin
        if (first_len < pmul_pkg::MAX_TERMS) begin
          first_coefs[first_len] = b.coef[pmul_pkg::EFF_BITS-1:0];
          first_len++;
        end
        if (b.last) first_closed = 1'b1;
      end
    end else begin
      if (!second_closed) begin
        if (second_len < pmul_pkg::MAX_TERMS) begin
          second_coefs[second_len] = b.coef[pmul_pkg::EFF_BITS-1:0];
          second_len++;
        end
        if (b.last) second_closed = 1'b1;
      end
    end
    if (!(first_closed && second_closed)) return;
    n_terms = first_len + second_len - 1;
    for (int k = 0; k < n_terms; k++) begin
      sum = '0;
      for (int i = 0; i < first_len; i++) begin
        if (k - i >= 0 && k - i < second_len) begin
          term = first_coefs[i] * second_coefs[k - i];
          sum  = sum + term;
        end
      end
      t.coef   = sum;
      t.degree = k[pmul_pkg::DEG_W-1:0];
      t.last   = (k == n_terms - 1);
      product_terms_due.push_back(t);
      results_due++;
    end
    first_len     = 0;
    second_len    = 0;
    first_closed  = 1'b0;
    second_closed = 1'b0;
  endfunction

  function automatic void push_beat(input logic sel,
                                    input logic [pmul_pkg::IN_COEF_W-1:0] coef,
                                    input logic last, input bit drain);
    coef_beat_t b;
    b.sel   = sel;
    b.coef  = coef;
    b.last  = last;
    b.drain = drain;
    coef_beats_to_send.push_back(b);
  endfunction

  // Coefficients lean toward the extremes, zero and minus one.
  function automatic logic [pmul_pkg::IN_COEF_W-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return pmul_pkg::IN_COEF_W'($urandom);
    endcase
  endfunction

  // Operand lengths are mostly short; some run up to the store capacity and a few past it.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(5, 1);
    if (r < 95) return $urandom_range(pmul_pkg::MAX_TERMS, 6);
    return $urandom_range(pmul_pkg::MAX_TERMS + 4, pmul_pkg::MAX_TERMS + 1);
  endfunction

  // Queues one well-formed pair with the two operands interleaved at random. While one
  // operand is closed and the other still loads, stray beats for the closed one are mixed in.
  task automatic queue_pair(input int n1, input int n2, input bit drain);
    int left1;
    int left2;
    bit to_second;
    bit hold_flag;
    left1     = n1;
    left2     = n2;
    hold_flag = drain;
    while (left1 > 0 || left2 > 0) begin
      if ((left1 == 0) != (left2 == 0) && $urandom_range(11) == 0) begin
        push_beat(left1 == 0 ? pmul_pkg::SEL_FIRST : pmul_pkg::SEL_SECOND, rand_coef(),
                  1'($urandom_range(1)), hold_flag);
      end else begin
        to_second = (left1 == 0) || (left2 != 0 && $urandom_range(1) == 1);
        if (to_second) begin
          push_beat(pmul_pkg::SEL_SECOND, rand_coef(), left2 == 1, hold_flag);
          left2--;
        end else begin
          push_beat(pmul_pkg::SEL_FIRST, rand_coef(), left1 == 1, hold_flag);
          left1--;
        end
      end
      hold_flag = 1'b0;
    end
  endtask

  // Sender: offers the head of the pending queue and holds it until the core takes it.
  always @(posedge clk) begin
    logic offer;
    offer = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        load_and_convolve(coef_beats_to_send.pop_front());
        beats_taken++;
      end
      if (s_tvalid && !s_tready) begin
        offer = 1'b1;
      end else if (coef_beats_to_send.size() != 0) begin
        if (coef_beats_to_send[0].drain && results_got != results_due) begin
          offer = 1'b0;
        end else begin
          offer = ($urandom_range(99) >= idle_pct(idle_phase, 1'b0));
        end
      end
      if (offer) begin
        s_tdata <= coef_beats_to_send[0].coef;
        s_tuser <= coef_beats_to_send[0].sel;
        s_tlast <= coef_beats_to_send[0].last;
      end
      s_tvalid <= offer;
      if (beats_taken < 170) begin
        idle_phase <= IDLE_SLOW_RX;
      end else if (beats_taken < 340) begin
        idle_phase <= IDLE_SLOW_TX;
      end else begin
        idle_phase <= IDLE_NONE;
      end
    end
  end

  // Receiver: checks each result beat against the oldest predicted term. After a fixed
  // number of results it refuses beats for a long stretch so the core backs up.
  always @(posedge clk) begin
    prod_term_t want;
    logic       ready_next;
    bit         took;
    took = m_tvalid && m_tready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (took) begin
        results_got <= results_got + 1;
        if (product_terms_due.size() == 0) begin
          note_error($sformatf("unexpected result coef=%0h degree=%0d last=%0b",
                               got_coef, got_deg, m_tlast));
        end else begin
          want = product_terms_due.pop_front();
          if (got_coef !== want.coef || got_deg !== want.degree || m_tlast !== want.last) begin
            note_error($sformatf("expected coef=%0h degree=%0d last=%0b, got %0h %0d %0b",
                                 want.coef, want.degree, want.last, got_coef, got_deg,
                                 m_tlast));
          end
        end
        if (results_got + 1 == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = ($urandom_range(99) >= idle_pct(idle_phase, 1'b1));
      end
      m_tready <= ready_next;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int fed;
    int n1;
    int n2;
    bit drained_once;

    // Single terms at the negative extreme.
    push_beat(pmul_pkg::SEL_FIRST, 16'h8000, 1'b1, 1'b0);
    push_beat(pmul_pkg::SEL_SECOND, 16'h8000, 1'b1, 1'b0);
    // First operand closes early; a further beat for it is ignored while the second loads.
    push_beat(pmul_pkg::SEL_FIRST, 16'h7fff, 1'b1, 1'b0);
    push_beat(pmul_pkg::SEL_FIRST, 16'h0007, 1'b0, 1'b0);
    push_beat(pmul_pkg::SEL_SECOND, 16'h7fff, 1'b0, 1'b0);
    push_beat(pmul_pkg::SEL_SECOND, 16'h8000, 1'b1, 1'b0);
    // Second operand closes before the first one starts.
    push_beat(pmul_pkg::SEL_SECOND, 16'hffff, 1'b1, 1'b0);
    push_beat(pmul_pkg::SEL_FIRST, 16'h0001, 1'b0, 1'b0);
    push_beat(pmul_pkg::SEL_FIRST, 16'hffff, 1'b1, 1'b0);
    // One coefficient past capacity: dropped, but its last flag still closes the operand.
    for (int i = 0; i <= pmul_pkg::MAX_TERMS; i++) begin
      push_beat(pmul_pkg::SEL_FIRST, 16'h8000, i == pmul_pkg::MAX_TERMS, 1'b0);
    end
    push_beat(pmul_pkg::SEL_SECOND, 16'h8000, 1'b0, 1'b0);
    push_beat(pmul_pkg::SEL_SECOND, 16'h8000, 1'b1, 1'b0);

    fed          = 0;
    drained_once = 1'b0;
    while (fed < RANDOM_BEATS) begin
      n1  = pick_len();
      n2  = pick_len();
      fed += n1 + n2;
      queue_pair(n1, n2, !drained_once && fed > DRAIN_AT_BEAT);
      if (fed > DRAIN_AT_BEAT) drained_once = 1'b1;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (coef_beats_to_send.size() != 0) @(posedge clk);
    while (results_got != results_due) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (product_terms_due.size() != 0) begin
      note_error($sformatf("%0d product terms never arrived", product_terms_due.size()));
    end

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
